@@ rtl/wrr_evs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wrr_evs_pkg;

  // sizing
  localparam int NUM_QUEUES = 8;
  localparam int MAX_EVENTS = 255;
  localparam int QADDR_W    = $clog2(NUM_QUEUES);
  localparam int QIDX_W     = 3;
  localparam int REQ_W      = 3;
  localparam int CRED_W     = 8;
  localparam int CNT_W      = 8;
  localparam int TOT_W      = 11;
  localparam int WEIGHTS_W  = 64;
  localparam int LIST_DEPTH = 8;
  localparam int LIST_IDX_W = 3;
  localparam int LEN_W      = 4;

  // request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_POST   = 3'd0,
    REQ_PICK   = 3'd1,
    REQ_PAUSE  = 3'd2,
    REQ_RESUME = 3'd3,
    REQ_DEACT  = 3'd4
  } req_kind_t;

  // per-queue entry held in the queue memory
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CRED_W-1:0] credit;
  } qentry_t;

  localparam int QENTRY_W = CNT_W + CRED_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_PK_RD,
    S_PK_EV,
    S_RL_CHK,
    S_RL_RD,
    S_RL_WR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/wrr_evs_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

// request channel
interface wrr_evs_req_if;
  import wrr_evs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [QIDX_W-1:0]     queue_index;
  modport source (output valid, req_type, queue_index, input ready);
  modport sink   (input valid, req_type, queue_index, output ready);
endinterface

// result channel
interface wrr_evs_res_if;
  import wrr_evs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  grant_valid;
  logic [QIDX_W-1:0]     grant_queue;
  logic [TOT_W-1:0]      total_credit;
  logic                  status;
  modport source (output valid, grant_valid, grant_queue, total_credit, status,
                  input ready);
  modport sink   (input valid, grant_valid, grant_queue, total_credit, status,
                  output ready);
endinterface

// weight register write channel
interface wrr_evs_cfg_if;
  import wrr_evs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WEIGHTS_W-1:0]  queue_weights;
  modport source (output valid, queue_weights, input ready);
  modport sink   (input valid, queue_weights, output ready);
endinterface

`default_nettype wire

@@ rtl/wrr_evs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wrr_evs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/weighted_round_robin_event_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Weighted round-robin scheduler over eight event queues. Each request gives
// exactly one result carrying the grant, the remaining total credit and a
// queue-full flag. Count and credit of every queue live in a small memory with
// a registered read; the activation order and the paused/active flags are
// registers. One request is handled at a time. Post, pause, resume and
// deactivate go through a memory read, an execute step and the result
// hand-off, the result reaching the output register at the hand-off; an
// unknown kind skips the read and execute steps. A pick examines the listed
// queues in order until a grant (up to 8 of them), and reloads every listed
// queue when the total credit runs out; every examined or reloaded queue
// costs one memory read and one evaluate or write step. A new request is taken
// as soon as the result is in the output register, even if it has not been
// taken yet; while an older result still waits there, the request holds in its
// hand-off step until the output register frees up.
module weighted_round_robin_event_scheduler (
  input wire logic     clk,
  input wire logic     rst_n,
  wrr_evs_req_if.sink  in_ch,
  wrr_evs_res_if.source out_ch,
  wrr_evs_cfg_if.sink  cfg_ch
);
  import wrr_evs_pkg::*;

  localparam logic [LEN_W-1:0] NQ_L     = LEN_W'(NUM_QUEUES);
  localparam logic [LEN_W-1:0] DEPTH_L  = LEN_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_EVENTS);

  state_t                  state_r, state_nxt;
  logic [REQ_W-1:0]        req_r, req_nxt;
  logic [QIDX_W-1:0]       q_r, q_nxt;
  logic [LIST_IDX_W-1:0]   idx_r, idx_nxt;
  logic [QIDX_W-1:0]       cand_r, cand_nxt;
  logic [LEN_W-1:0]        len_r, len_nxt;
  logic [TOT_W-1:0]        total_r, total_nxt;
  logic [NUM_QUEUES-1:0]   active_r, active_nxt;
  logic [NUM_QUEUES-1:0]   paused_r, paused_nxt;
  logic [NUM_QUEUES-1:0]   qv_r, qv_nxt;
  logic [WEIGHTS_W-1:0]    weights_r, weights_nxt;
  logic [QIDX_W-1:0]       order_r [LIST_DEPTH];
  logic [QIDX_W-1:0]       order_nxt [LIST_DEPTH];
  logic [QIDX_W-1:0]       rm_list [LIST_DEPTH];
  logic                    res_gv_r, res_gv_nxt;
  logic [QIDX_W-1:0]       res_gq_r, res_gq_nxt;
  logic                    res_st_r, res_st_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_gv_r, out_gv_nxt;
  logic [QIDX_W-1:0]       out_gq_r, out_gq_nxt;
  logic [TOT_W-1:0]        out_tot_r, out_tot_nxt;
  logic                    out_st_r, out_st_nxt;
  logic                    rd_ok_r;

  // queue memory port signals
  logic                    q_we;
  logic [QADDR_W-1:0]      q_waddr;
  qentry_t                 q_wdata;
  logic [QADDR_W-1:0]      q_raddr;
  logic [QENTRY_W-1:0]     q_rdata;
  qentry_t                 q_ent;

  logic [QIDX_W-1:0]       rm_q;
  logic                    do_rm;
  logic [QADDR_W-1:0]      qa;
  logic [QADDR_W-1:0]      ca;
  logic [CRED_W-1:0]       w_q;
  logic [CRED_W-1:0]       w_c;
  logic [CRED_W-1:0]       new_cr;
  logic [CNT_W-1:0]        new_cnt;
  logic                    kind_ok;
  logic                    qok_in;
  logic                    last_idx;

  function automatic logic [TOT_W-1:0] sat_sub(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    sat_sub = (a > b) ? (a - b) : '0;
  endfunction

  wrr_evs_ram #(
    .WIDTH (QENTRY_W),
    .DEPTH (NUM_QUEUES)
  ) u_qram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  // never-written entries read as zero
  assign q_ent = rd_ok_r ? qentry_t'(q_rdata) : '0;

  assign qa       = q_r[QADDR_W-1:0];
  assign ca       = cand_r[QADDR_W-1:0];
  assign w_q      = weights_r[{q_r, 3'b000} +: CRED_W];
  assign w_c      = weights_r[{cand_r, 3'b000} +: CRED_W];
  assign last_idx = (LEN_W'({1'b0, idx_r}) + LEN_W'(1)) >= len_r;
  assign qok_in   = {1'b0, in_ch.queue_index} < NQ_L;
  assign kind_ok  = (in_ch.req_type == REQ_POST) || (in_ch.req_type == REQ_PAUSE) ||
                    (in_ch.req_type == REQ_RESUME) || (in_ch.req_type == REQ_DEACT);

  // memory read address
  always_comb begin
    unique case (state_r)
      S_PK_RD, S_RL_RD: q_raddr = order_r[idx_r][QADDR_W-1:0];
      default:          q_raddr = in_ch.queue_index[QADDR_W-1:0];
    endcase
  end

  // order list with one queue taken out, later entries move up
  assign rm_q = (state_r == S_PK_EV) ? cand_r : q_r;
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int j = 0; j < LIST_DEPTH; j++) begin
      if ((order_r[j] == rm_q) && (LEN_W'(j) < len_r)) begin
        seen = 1'b1;
      end
      if (seen && (j < LIST_DEPTH - 1)) begin
        rm_list[j] = order_r[(j + 1) % LIST_DEPTH];
      end else begin
        rm_list[j] = order_r[j];
      end
    end
  end

  // sequencer: next state, memory writes and result
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    q_nxt       = q_r;
    idx_nxt     = idx_r;
    cand_nxt    = cand_r;
    len_nxt     = len_r;
    total_nxt   = total_r;
    active_nxt  = active_r;
    paused_nxt  = paused_r;
    weights_nxt = weights_r;
    order_nxt   = order_r;
    res_gv_nxt  = res_gv_r;
    res_gq_nxt  = res_gq_r;
    res_st_nxt  = res_st_r;
    out_gv_nxt  = out_gv_r;
    out_gq_nxt  = out_gq_r;
    out_tot_nxt = out_tot_r;
    out_st_nxt  = out_st_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_we        = 1'b0;
    q_waddr     = qa;
    q_wdata     = '0;
    do_rm       = 1'b0;
    new_cr      = q_ent.credit;
    new_cnt     = q_ent.count;

    if (cfg_ch.valid) begin
      weights_nxt = cfg_ch.queue_weights;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt    = in_ch.req_type;
          q_nxt      = in_ch.queue_index;
          idx_nxt    = '0;
          res_gv_nxt = 1'b0;
          res_gq_nxt = '0;
          res_st_nxt = 1'b0;
          if (in_ch.req_type == REQ_PICK) begin
            state_nxt = (len_r == '0) ? S_RL_CHK : S_PK_RD;
          end else if (kind_ok && qok_in) begin
            state_nxt = S_EXEC;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      // single-queue requests, entry data is here
      S_EXEC: begin
        state_nxt = S_DONE;
        unique case (req_r)
          REQ_POST: begin
            if (q_ent.count >= MAX_CNT) begin
              res_st_nxt = 1'b1;
            end else begin
              new_cnt = q_ent.count + CNT_W'(1);
              if (!active_r[qa] && (len_r < DEPTH_L)) begin
                new_cr = w_q;
                if (!paused_r[qa]) begin
                  total_nxt = total_r + TOT_W'(w_q);
                end
                order_nxt[len_r[LIST_IDX_W-1:0]] = q_r;
                len_nxt        = len_r + LEN_W'(1);
                active_nxt[qa] = 1'b1;
              end
              q_we    = 1'b1;
              q_wdata = '{count: new_cnt, credit: new_cr};
            end
          end
          REQ_PAUSE: begin
            if (!paused_r[qa]) begin
              paused_nxt[qa] = 1'b1;
              if (active_r[qa]) begin
                total_nxt = sat_sub(total_r, TOT_W'(q_ent.credit));
              end
            end
          end
          REQ_RESUME: begin
            if (paused_r[qa]) begin
              paused_nxt[qa] = 1'b0;
              if (active_r[qa]) begin
                total_nxt = total_r + TOT_W'(q_ent.credit);
              end
            end
          end
          REQ_DEACT: begin
            if ((q_ent.count == '0) && active_r[qa]) begin
              if (!paused_r[qa]) begin
                total_nxt = sat_sub(total_r, TOT_W'(q_ent.credit));
              end
              q_we           = 1'b1;
              q_wdata        = '0;
              active_nxt[qa] = 1'b0;
              do_rm          = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // pick walk: fetch next listed queue
      S_PK_RD: begin
        cand_nxt  = order_r[idx_r];
        state_nxt = S_PK_EV;
      end

      S_PK_EV: begin
        if (!paused_r[ca] && (q_ent.credit != '0)) begin
          res_gv_nxt = 1'b1;
          res_gq_nxt = cand_r;
          new_cnt    = (q_ent.count != '0) ? q_ent.count - CNT_W'(1) : '0;
          q_we       = 1'b1;
          q_waddr    = ca;
          if (new_cnt == '0) begin
            // emptied: spent credit and the rest leave the total together
            total_nxt      = sat_sub(total_r, TOT_W'(q_ent.credit));
            q_wdata        = '0;
            active_nxt[ca] = 1'b0;
            do_rm          = 1'b1;
          end else begin
            total_nxt = sat_sub(total_r, TOT_W'(1));
            q_wdata   = '{count: new_cnt, credit: q_ent.credit - CRED_W'(1)};
          end
          state_nxt = S_RL_CHK;
        end else if (last_idx) begin
          state_nxt = S_RL_CHK;
        end else begin
          idx_nxt   = idx_r + LIST_IDX_W'(1);
          state_nxt = S_PK_RD;
        end
      end

      S_RL_CHK: begin
        if ((total_r == '0) && (len_r != '0)) begin
          idx_nxt   = '0;
          state_nxt = S_RL_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // reload walk: read entry, then rewrite credit keeping the count
      S_RL_RD: begin
        cand_nxt  = order_r[idx_r];
        state_nxt = S_RL_WR;
      end

      S_RL_WR: begin
        q_we    = 1'b1;
        q_waddr = ca;
        q_wdata = '{count: q_ent.count, credit: w_c};
        if (!paused_r[ca]) begin
          total_nxt = total_r + TOT_W'(w_c);
        end
        if (last_idx) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + LIST_IDX_W'(1);
          state_nxt = S_RL_RD;
        end
      end

      // hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_gv_nxt    = res_gv_r;
          out_gq_nxt    = res_gq_r;
          out_tot_nxt   = total_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (do_rm) begin
      order_nxt = rm_list;
      len_nxt   = len_r - LEN_W'(1);
    end
  end

  // entry valid bits follow memory writes
  always_comb begin
    qv_nxt = qv_r;
    if (q_we) begin
      qv_nxt[q_waddr] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      total_r     <= '0;
      active_r    <= '0;
      paused_r    <= '0;
      qv_r        <= '0;
      weights_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      total_r     <= total_nxt;
      active_r    <= active_nxt;
      paused_r    <= paused_nxt;
      qv_r        <= qv_nxt;
      weights_r   <= weights_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    q_r       <= q_nxt;
    idx_r     <= idx_nxt;
    cand_r    <= cand_nxt;
    order_r   <= order_nxt;
    res_gv_r  <= res_gv_nxt;
    res_gq_r  <= res_gq_nxt;
    res_st_r  <= res_st_nxt;
    out_gv_r  <= out_gv_nxt;
    out_gq_r  <= out_gq_nxt;
    out_tot_r <= out_tot_nxt;
    out_st_r  <= out_st_nxt;
    rd_ok_r   <= qv_r[q_raddr];
  end

  // channel outputs
  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.grant_valid  = out_gv_r;
  assign out_ch.grant_queue  = out_gq_r;
  assign out_ch.total_credit = out_tot_r;
  assign out_ch.status       = out_st_r;

endmodule

`default_nettype wire
